/* rtl/core/pidaw_pkg.sv */
// ----------------------------------------------------------------------------
// PID step package
// Shared widths, register indexes and reset values for the PID step block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	localparam int ACC_W  = 32;
	localparam int GAIN_W = 16;
	localparam int DEN_W  = 15;
	localparam int LIM_W  = 15;
	localparam int PROD_W = ACC_W + GAIN_W;
	localparam int OUT_W  = 32;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 16;
	localparam int MCNT_W = $clog2(GAIN_W);
	localparam int DCNT_W = $clog2(PROD_W);

	localparam logic [IDX_W-1:0] REG_PRESCALE = 3'd0;
	localparam logic [IDX_W-1:0] REG_PROP     = 3'd1;
	localparam logic [IDX_W-1:0] REG_INTEG    = 3'd2;
	localparam logic [IDX_W-1:0] REG_DERIV    = 3'd3;
	localparam logic [IDX_W-1:0] REG_NUMER    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DENOM    = 3'd5;
	localparam logic [IDX_W-1:0] REG_WINDUP   = 3'd6;

	localparam logic [GAIN_W-1:0] RST_PRESCALE = 16'sd1;
	localparam logic [GAIN_W-1:0] RST_NUMER    = 16'sd1;
	localparam logic [DEN_W-1:0]  RST_DENOM    = 15'd1;
	localparam logic [LIM_W-1:0]  RST_WINDUP   = 15'd5000;

endpackage

/* rtl/core/pidaw_smul.sv */
// ----------------------------------------------------------------------------
// PID step serial multiplier
// Shift-add signed multiply, one multiplier bit per cycle, wrapping product.
// ----------------------------------------------------------------------------
module pidaw_smul
	import pidaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] a,
	input  logic [GAIN_W-1:0] b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic              done_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [PROD_W-1:0] a_q;
	logic [GAIN_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] addend;
	logic              last;

	assign last   = (cnt_q == MCNT_W'(GAIN_W - 1));
	assign addend = b_q[0] ? a_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			// sign bit of the multiplier carries negative weight
			acc_q <= last ? (acc_q - addend) : (acc_q + addend);
			a_q   <= {a_q[PROD_W-2:0], 1'b0};
			b_q   <= {1'b0, b_q[GAIN_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/core/pidaw_sdiv.sv */
// ----------------------------------------------------------------------------
// PID step serial divider
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidaw_sdiv
	import pidaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DEN_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/pid_step_antiwindup.sv */
// ----------------------------------------------------------------------------
// PID step with integrator clamp
// One error sample in, one drive value out, through a shared serial
// multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Each item runs as five signed multiplies on the one shift-add multiplier
// (one gain bit per cycle): prescale, integral gain, proportional gain,
// derivative gain and output numerator; then the restoring divider (one
// quotient bit per cycle over the 48-bit product), then the load of the
// output register. One item is worked on at a time; the finished drive value
// sits in an output register, so the next item is taken while it waits, and a
// finished item holds until that register is free. Write the registers only
// while the block is idle.
module pid_step_antiwindup
	import pidaw_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [GAIN_W-1:0] err_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  drive
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCALE = 3'd1;
	localparam logic [2:0] ST_INTEG = 3'd2;
	localparam logic [2:0] ST_PROP  = 3'd3;
	localparam logic [2:0] ST_DERIV = 3'd4;
	localparam logic [2:0] ST_OUTM  = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]        state_q;
	logic [GAIN_W-1:0] prescale_q;
	logic [GAIN_W-1:0] prop_q;
	logic [GAIN_W-1:0] integ_q;
	logic [GAIN_W-1:0] deriv_q;
	logic [GAIN_W-1:0] numer_q;
	logic [DEN_W-1:0]  denom_q;
	logic [LIM_W-1:0]  windup_q;

	logic [ACC_W-1:0]  last_q;
	logic [ACC_W-1:0]  sum_q;
	logic [ACC_W-1:0]  scaled_q;
	logic [ACC_W-1:0]  delta_q;
	logic [ACC_W-1:0]  iterm_q;
	logic [ACC_W-1:0]  total_q;
	logic              neg_q;
	logic [OUT_W-1:0]  res_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  drive_q;

	logic              in_acc;
	logic              slot_free;
	logic              mul_start;
	logic [PROD_W-1:0] mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic              div_start;
	logic [PROD_W-1:0] div_mag;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [PROD_W-1:0] div_quo;
	logic [PROD_W-1:0] quo_signed;
	logic [ACC_W-1:0]  mul_low;
	logic [ACC_W-1:0]  total_nx;
	logic signed [ACC_W:0] iterm_ext;
	logic signed [ACC_W:0] lim_ext;
	logic              in_window;

	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign mul_low   = mul_prod[ACC_W-1:0];
	assign total_nx  = total_q + mul_low;

	assign iterm_ext = $signed({mul_low[ACC_W-1], mul_low});
	assign lim_ext   = $signed({{(ACC_W + 1 - LIM_W){1'b0}}, windup_q});
	assign in_window = (iterm_ext < lim_ext) && (iterm_ext > -lim_ext);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				mul_start = in_acc;
				mul_a     = {{(PROD_W - GAIN_W){err_sample[GAIN_W-1]}}, err_sample};
				mul_b     = prescale_q;
			end
			ST_SCALE: begin
				mul_start = mul_done;
				mul_a     = {{(PROD_W - ACC_W){sum_q[ACC_W-1]}}, sum_q};
				mul_b     = integ_q;
			end
			ST_INTEG: begin
				mul_start = mul_done;
				mul_a     = {{(PROD_W - ACC_W){scaled_q[ACC_W-1]}}, scaled_q};
				mul_b     = prop_q;
			end
			ST_PROP: begin
				mul_start = mul_done;
				mul_a     = {{(PROD_W - ACC_W){delta_q[ACC_W-1]}}, delta_q};
				mul_b     = deriv_q;
			end
			ST_DERIV: begin
				mul_start = mul_done;
				mul_a     = {{(PROD_W - ACC_W){total_nx[ACC_W-1]}}, total_nx};
				mul_b     = numer_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start  = (state_q == ST_OUTM) && mul_done;
	assign div_mag    = mul_prod[PROD_W-1] ? (~mul_prod + 1'b1) : mul_prod;
	assign div_den    = (denom_q == '0) ? DEN_W'(1) : denom_q;
	assign quo_signed = neg_q ? (~div_quo + 1'b1) : div_quo;

	pidaw_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pidaw_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= RST_PRESCALE;
			prop_q     <= '0;
			integ_q    <= '0;
			deriv_q    <= '0;
			numer_q    <= RST_NUMER;
			denom_q    <= RST_DENOM;
			windup_q   <= RST_WINDUP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESCALE: prescale_q <= cfg_data;
				REG_PROP:     prop_q     <= cfg_data;
				REG_INTEG:    integ_q    <= cfg_data;
				REG_DERIV:    deriv_q    <= cfg_data;
				REG_NUMER:    numer_q    <= cfg_data;
				REG_DENOM:    denom_q    <= cfg_data[DEN_W-1:0];
				REG_WINDUP:   windup_q   <= cfg_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (mul_done)
						state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					if (mul_done) begin
						last_q <= scaled_q;
						if (in_window)
							sum_q <= sum_q + scaled_q;
						state_q <= ST_PROP;
					end
				end
				ST_PROP: begin
					if (mul_done)
						state_q <= ST_DERIV;
				end
				ST_DERIV: begin
					if (mul_done)
						state_q <= ST_OUTM;
				end
				ST_OUTM: begin
					if (mul_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE && mul_done) begin
			scaled_q <= mul_low;
			delta_q  <= mul_low - last_q;
		end
		if (state_q == ST_INTEG && mul_done)
			iterm_q <= mul_low;
		if (state_q == ST_PROP && mul_done)
			total_q <= mul_low + iterm_q;
		if (state_q == ST_DERIV && mul_done)
			total_q <= total_nx;
		if (div_start)
			neg_q <= mul_prod[PROD_W-1];
		if (state_q == ST_DIV && div_done)
			res_q <= quo_signed[OUT_W-1:0];
		if (state_q == ST_FIN && slot_free)
			drive_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID step with integrator clamp: testbench
// Drives error samples through the valid/stall input channel, mirrors the
// controller state and the gain registers in a local predictor, and checks
// every drive value against the oldest predicted one. Directed cases cover
// register reset values, field extremes, wrap, zero divisor, zero and small
// windup limits and an ignored register index; random phases then vary gains
// and idling on both channels, and a last case adds one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import pidaw_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 1000;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int ITEMS_PER_SETTING = 120;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [GAIN_W-1:0] err_sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [OUT_W-1:0]  drive;

	// register mirror
	logic signed [GAIN_W-1:0] m_prescale = RST_PRESCALE;
	logic signed [GAIN_W-1:0] m_prop = '0;
	logic signed [GAIN_W-1:0] m_integ = '0;
	logic signed [GAIN_W-1:0] m_deriv = '0;
	logic signed [GAIN_W-1:0] m_numer = RST_NUMER;
	logic [DEN_W-1:0]         m_denom = RST_DENOM;
	logic [LIM_W-1:0]         m_windup = RST_WINDUP;
	// controller state mirror
	logic signed [31:0]       m_last = '0;
	logic signed [31:0]       m_sum = '0;

	logic signed [OUT_W-1:0]  drive_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_epoch = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	pid_step_antiwindup dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.err_sample(err_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive(drive)
	);

	always #10 clk = ~clk;

	function automatic logic signed [31:0] pid_predict(input logic signed [GAIN_W-1:0] s);
		logic signed [31:0] scaled;
		logic signed [31:0] delta;
		logic signed [31:0] iterm;
		logic signed [31:0] total;
		logic signed [31:0] lim;
		logic signed [63:0] prod;
		logic signed [63:0] den;
		logic signed [63:0] quo;
		scaled = s * m_prescale;
		delta = scaled - m_last;
		iterm = m_sum * m_integ;
		lim = $signed({17'd0, m_windup});
		m_last = scaled;
		if (iterm < lim && iterm > -lim)
			m_sum = m_sum + scaled;
		total = scaled * m_prop + iterm + m_deriv * delta;
		prod = total * m_numer;
		den = (m_denom == '0) ? 64'sd1 : $signed({49'd0, m_denom});
		quo = prod / den;
		return quo[31:0];
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_PRESCALE: m_prescale = data;
			REG_PROP:     m_prop = data;
			REG_INTEG:    m_integ = data;
			REG_DERIV:    m_deriv = data;
			REG_NUMER:    m_numer = data;
			REG_DENOM:    m_denom = data[DEN_W-1:0];
			REG_WINDUP:   m_windup = data[LIM_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [CFG_W-1:0] pre, input logic [CFG_W-1:0] kp,
			input logic [CFG_W-1:0] ki, input logic [CFG_W-1:0] kd,
			input logic [CFG_W-1:0] num, input logic [CFG_W-1:0] den,
			input logic [CFG_W-1:0] lim);
		write_reg(REG_PRESCALE, pre);
		write_reg(REG_PROP, kp);
		write_reg(REG_INTEG, ki);
		write_reg(REG_DERIV, kd);
		write_reg(REG_NUMER, num);
		write_reg(REG_DENOM, den);
		write_reg(REG_WINDUP, lim);
	endtask

	task automatic send_item(input logic signed [GAIN_W-1:0] s);
		int gap;
		in_valid <= 1'b1;
		err_sample <= s;
		do @(posedge clk); while (in_stall);
		drive_q.push_back(pid_predict(s));
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 250);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait for every outstanding drive value
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (drive_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 16) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_denom();
		logic [DEN_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = 15'd1;
			1: v = 15'h7fff;
			2: v = 15'd0;
			3: v = 15'($urandom_range(1, 16));
			default: v = 15'($urandom);
		endcase
		return {1'($urandom_range(0, 1)), v};
	endfunction

	function automatic logic [CFG_W-1:0] rand_windup();
		logic [LIM_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = 15'd0;
			1: v = 15'h7fff;
			2: v = 15'($urandom_range(1, 200));
			default: v = 15'($urandom);
		endcase
		return {1'($urandom_range(0, 1)), v};
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_err(input logic signed [GAIN_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2: return prev;
			3: return 16'sh7fff;
			4: return 16'sh8000;
			5, 6: return 16'($urandom_range(0, 128) - 64);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_item(16'sd1234);
		send_item(-16'sd77);
		settle();
		write_reg(REG_PROP, 16'd1);
		send_item(16'sh7fff);
		send_item(16'sh8000);
		send_item(16'sd0);
		send_item(16'sd1);
		send_item(-16'sd1);
		settle();
	endtask

	task automatic test_extremes_wrap();
		write_all(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
		send_item(16'sh7fff);
		send_item(16'sh8000);
		send_item(16'sh8000);
		send_item(16'sh7fff);
		send_item(16'sd0);
		settle();
	endtask

	task automatic test_zero_denominator();
		write_all(16'd3, 16'h7fff, 16'd0, 16'h8000, 16'h7fff, 16'h8000, 16'd5000);
		send_item(16'sh7fff);
		send_item(16'sh8000);
		send_item(16'sd99);
		settle();
	endtask

	task automatic test_windup_clamp();
		write_all(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1, 16'd100);
		repeat (4) send_item(16'sd60);
		settle();
		write_reg(REG_WINDUP, 16'd0);
		send_item(16'sd500);
		send_item(-16'sd500);
		send_item(16'sd7);
		settle();
	endtask

	task automatic test_ignored_index();
		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_UNUSED, 16'hffff);
		send_item(16'sd321);
		send_item(-16'sd4321);
		settle();
	endtask

	task automatic test_random_phases();
		int send_pct[4] = '{0, 65, 0, 38};
		int stall_pct[4] = '{0, 0, 65, 38};
		logic signed [GAIN_W-1:0] e;
		e = '0;
		for (int p = 0; p < 4; p++) begin
			for (int c = 0; c < 4; c++) begin
				settle();
				write_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					rand_denom(), rand_windup());
				send_idle_pct = send_pct[p];
				recv_stall_pct = stall_pct[p];
				for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
					e = rand_err(e);
					send_item(e);
				end
			end
		end
		settle();
	endtask

	task automatic test_backpressure();
		settle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(16'd2, 16'd3, 16'd1, 16'hfffe, 16'd5, 16'd3, 16'd2000);
		hold_epoch++;
		repeat (12) send_item(16'($urandom));
		settle();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_epoch) begin
			hold_seen <= hold_epoch;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				$display("%0t: unexpected drive, expected none, actual %0d", $time, drive);
				errors++;
			end else begin
				want = drive_q.pop_front();
				if (drive !== want) begin
					$display("%0t: drive mismatch, expected %0d, actual %0d",
						$time, want, drive);
					errors++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extremes_wrap();
		test_zero_denominator();
		test_windup_clamp();
		test_ignored_index();
		test_random_phases();
		test_backpressure();
		recv_stall_pct = 0;
		settle();
		repeat (200) @(posedge clk);
		if (drive_q.size() != 0)
			$display("%0t: %0d drive values never arrived", $time, drive_q.size());
		if (errors == 0 && drive_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
